[sv/websocket_frame_deframer_defines.svh]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_defines
// Assertion macros for the WebSocket deframer.
// ----------------------------------------------------------------------------
// Both expect a clock named clk and a synchronous reset named rst in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types, constants and character tables for the WebSocket deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Default receive buffer size in bytes; payloads keep at most one less
  localparam int BUFFER_BYTES_DEF = 1024;

  // Width of the kept_length result field
  localparam int KEPT_W = 10;

  // Depth of the queue between parser and result stage
  localparam int Q_DEPTH = 2;

  // Short length codes in the second header byte
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Frame opcodes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Reply action codes
  localparam logic [2:0] REPLY_NONE    = 3'd0;
  localparam logic [2:0] REPLY_PONG    = 3'd1;
  localparam logic [2:0] REPLY_CLOSE   = 3'd2;
  localparam logic [2:0] REPLY_TEXTPNG = 3'd3;
  localparam logic [2:0] REPLY_PONGSEEN = 3'd4;
  localparam logic [2:0] REPLY_UNKNOWN = 3'd5;

  // One parsed item travelling from parser to result stage
  typedef struct packed {
    logic [7:0]        data_byte;
    logic              has_data;
    logic [3:0]        frame_opcode;
    logic              final_fragment;
    logic              last_of_frame;
    logic              was_truncated;
    logic [KEPT_W-1:0] kept_length;
  } item_t;

  // Queue status seen by the result stage
  typedef struct packed {
    logic has_space;
    logic has_item;
  } q_status_t;

  // Characters of the text word "ping"
  function automatic logic [7:0] ping_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h70;
      2'd1:    c = 8'h69;
      2'd2:    c = 8'h6E;
      default: c = 8'h67;
    endcase
    return c;
  endfunction

  // Characters of the text word "pong"
  function automatic logic [7:0] pong_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h70;
      2'd1:    c = 8'h6F;
      2'd2:    c = 8'h6E;
      default: c = 8'h67;
    endcase
    return c;
  endfunction

endpackage

[sv/wsd_if.sv]
// ----------------------------------------------------------------------------
// wsd_byte_if / wsd_result_if
// Valid/ready channels for the raw byte stream and the deframed results.
// ----------------------------------------------------------------------------
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_result_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 data_byte;
  logic                       has_data;
  logic [3:0]                 frame_opcode;
  logic                       final_fragment;
  logic                       last_of_frame;
  logic                       was_truncated;
  logic [wsd_pkg::KEPT_W-1:0] kept_length;
  logic [2:0]                 reply_action;

  modport source (output valid, output data_byte, output has_data, output frame_opcode,
                  output final_fragment, output last_of_frame, output was_truncated,
                  output kept_length, output reply_action, input ready);
  modport sink   (input valid, input data_byte, input has_data, input frame_opcode,
                  input final_fragment, input last_of_frame, input was_truncated,
                  input kept_length, input reply_action, output ready);
endinterface

[sv/wsd_front.sv]
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: takes one byte a cycle while the queue has space, tracks the frame header, unmasks
// payload bytes and pushes one item per payload byte or empty-frame marker.
// ----------------------------------------------------------------------------
module wsd_front #(
  parameter int BUFFER_BYTES = wsd_pkg::BUFFER_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  wsd_byte_if.sink        frame,
  input  logic            space,
  output logic            push,
  output wsd_pkg::item_t  item
);

  localparam int          CW    = $clog2(BUFFER_BYTES) + 1;
  localparam int          KW    = wsd_pkg::KEPT_W;
  localparam logic [63:0] LIMIT = 64'(BUFFER_BYTES - 1);

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  logic [2:0]    phase, phase_next;
  logic          fin, fin_next;
  logic [3:0]    opcode, opcode_next;
  logic          masked, masked_next;
  logic [63:0]   len, len_next;
  logic [2:0]    hcount, hcount_next;
  logic [31:0]   mask, mask_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] kept, kept_next;
  logic [63:0]   skip, skip_next;

  logic          accept;
  logic [7:0]    b;
  logic          len_done;
  logic          start;
  logic [63:0]   kept_w;
  logic [7:0]    key_byte;
  logic [7:0]    plain;
  logic [CW-1:0] cnt1;
  logic          is_last;

  assign frame.ready = space;
  assign accept      = frame.valid && space;
  assign b           = frame.in_byte;

  // Select the key byte for this payload position
  always_comb begin
    case (count[1:0])
      2'd0:    key_byte = mask[31:24];
      2'd1:    key_byte = mask[23:16];
      2'd2:    key_byte = mask[15:8];
      default: key_byte = mask[7:0];
    endcase
  end

  assign plain   = b ^ key_byte;
  assign cnt1    = count + CW'(1);
  assign is_last = (cnt1 >= kept);
  assign kept_w  = (len_next > LIMIT) ? LIMIT : len_next;

  // Parse one byte and build the pushed item
  always_comb begin
    phase_next  = phase;
    fin_next    = fin;
    opcode_next = opcode;
    masked_next = masked;
    len_next    = len;
    hcount_next = hcount;
    mask_next   = mask;
    count_next  = count;
    kept_next   = kept;
    skip_next   = skip;
    len_done    = 1'b0;
    start       = 1'b0;
    push        = 1'b0;
    item        = '0;
    item.frame_opcode   = opcode;
    item.final_fragment = fin;

    if (accept) begin
      unique case (phase)
        PH_HDR0: begin
          fin_next    = b[7];
          opcode_next = b[3:0];
          phase_next  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_next = b[7];
          if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64) begin
            hcount_next = (b[6:0] == wsd_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
            len_next    = '0;
            phase_next  = PH_EXTLEN;
          end else begin
            len_next = {57'b0, b[6:0]};
            len_done = 1'b1;
          end
        end
        PH_EXTLEN: begin
          len_next = {len[55:0], b};
          if (hcount == 3'd0) begin
            len_done = 1'b1;
          end else begin
            hcount_next = hcount - 3'd1;
          end
        end
        PH_MASK: begin
          mask_next = {mask[23:0], b};
          if (hcount == 3'd0) begin
            start = 1'b1;
          end else begin
            hcount_next = hcount - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          push                = 1'b1;
          item.data_byte      = plain;
          item.has_data       = 1'b1;
          item.last_of_frame  = is_last;
          item.was_truncated  = (skip != '0);
          item.kept_length    = KW'(cnt1);
          count_next          = cnt1;
          if (is_last) begin
            phase_next = (skip != '0) ? PH_SKIP : PH_HDR0;
          end
        end
        PH_SKIP: begin
          skip_next = skip - 64'd1;
          if (skip_next == '0) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      // Length known: fetch the key, or go straight to the payload
      if (len_done) begin
        mask_next = '0;
        if (masked_next) begin
          hcount_next = 3'd3;
          phase_next  = PH_MASK;
        end else begin
          start = 1'b1;
        end
      end

      // Clip the payload to the buffer and note the excess to skip
      if (start) begin
        kept_next  = CW'(kept_w);
        skip_next  = len_next - kept_w;
        count_next = '0;
        if (kept_w == '0) begin
          push               = 1'b1;
          item.last_of_frame = 1'b1;
          phase_next         = PH_HDR0;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
    end else begin
      phase <= phase_next;
    end
    fin    <= fin_next;
    opcode <= opcode_next;
    masked <= masked_next;
    len    <= len_next;
    hcount <= hcount_next;
    mask   <= mask_next;
    count  <= count_next;
    kept   <= kept_next;
    skip   <= skip_next;
  end

endmodule

[sv/wsd_queue.sv]
// ----------------------------------------------------------------------------
// wsd_queue
// Short first-in first-out queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module wsd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wsd_pkg::item_t      push_item,
  input  logic                pop,
  output wsd_pkg::item_t      head_item,
  output wsd_pkg::q_status_t  status
);

  localparam int DEPTH = wsd_pkg::Q_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);

  wsd_pkg::item_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [LW-1:0]  level;

  assign status.has_space = (level != LW'(DEPTH));
  assign status.has_item  = (level != '0);
  assign head_item        = mem[rd_ptr];

  // Write the incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

[sv/wsd_back.sv]
// ----------------------------------------------------------------------------
// wsd_back
// Result stage: matches four-byte text payloads, decides the reply action on
// the last item of a frame and holds the result in an output register.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic                clk,
  input  logic                rst,
  input  wsd_pkg::q_status_t  status,
  input  wsd_pkg::item_t      head_item,
  output logic                pop,
  wsd_result_if.source        result
);

  logic       out_valid;
  logic [1:0] flags, flags_next;
  logic [2:0] pos, pos_next;
  logic [2:0] reply;
  logic       four;

  assign pop          = status.has_item && (!out_valid || result.ready);
  assign result.valid = out_valid;

  // Track the text word match over the first bytes of the frame
  always_comb begin
    flags_next = flags;
    pos_next   = pos;
    if (head_item.has_data) begin
      if (pos < 3'd4) begin
        if (head_item.data_byte != wsd_pkg::ping_char(pos[1:0])) flags_next[0] = 1'b0;
        if (head_item.data_byte != wsd_pkg::pong_char(pos[1:0])) flags_next[1] = 1'b0;
      end else begin
        flags_next = 2'b00;
      end
      if (pos < 3'd5) begin
        pos_next = pos + 3'd1;
      end
    end
  end

  assign four = (pos_next == 3'd4);

  // Decode the reply action for the frame's last item
  always_comb begin
    reply = wsd_pkg::REPLY_NONE;
    if (head_item.last_of_frame) begin
      unique case (head_item.frame_opcode)
        wsd_pkg::OP_TEXT: begin
          if (four && flags_next[0]) begin
            reply = wsd_pkg::REPLY_TEXTPNG;
          end else if (four && flags_next[1]) begin
            reply = wsd_pkg::REPLY_PONGSEEN;
          end else begin
            reply = wsd_pkg::REPLY_NONE;
          end
        end
        wsd_pkg::OP_BINARY: reply = wsd_pkg::REPLY_NONE;
        wsd_pkg::OP_CLOSE:  reply = wsd_pkg::REPLY_CLOSE;
        wsd_pkg::OP_PING:   reply = wsd_pkg::REPLY_PONG;
        wsd_pkg::OP_PONG:   reply = wsd_pkg::REPLY_PONGSEEN;
        default:            reply = wsd_pkg::REPLY_UNKNOWN;
      endcase
    end
  end

  // Hold control state; restart matching after each frame
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= 2'b11;
      pos       <= 3'd0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        flags     <= head_item.last_of_frame ? 2'b11 : flags_next;
        pos       <= head_item.last_of_frame ? 3'd0 : pos_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      result.data_byte      <= head_item.data_byte;
      result.has_data       <= head_item.has_data;
      result.frame_opcode   <= head_item.frame_opcode;
      result.final_fragment <= head_item.final_fragment;
      result.last_of_frame  <= head_item.last_of_frame;
      result.was_truncated  <= head_item.was_truncated;
      result.kept_length    <= head_item.kept_length;
      result.reply_action   <= reply;
    end
  end

endmodule

[sv/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket deframer: raw bytes in, unmasked payload items out.
// ----------------------------------------------------------------------------
// Channels: frame carries one raw stream byte per item (in_byte); result
// carries one item per payload byte, or a single marker item (has_data low)
// for a frame with an empty payload. Header, length, key and skipped excess
// bytes produce no result item. The last item of a frame carries
// last_of_frame, the kept payload length and the reply action.
// Throughput: one byte per cycle while the queue has space.
// Path: a taken payload byte is written into the parser-to-result queue,
// then loads the output register, from which the result is presented.
// Reset: the parser expects the first header byte, the queue is emptied and
// no result is valid. Stall: while result.ready is low a valid output
// register holds; the two-entry queue takes bytes until full, then
// frame.ready drops. Payloads longer than BUFFER_BYTES-1 are clipped; the
// excess is consumed one byte per cycle while the queue has space, with no
// result, and was_truncated marks the frame.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer #(
  parameter int BUFFER_BYTES = wsd_pkg::BUFFER_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  wsd_byte_if.sink      frame,
  wsd_result_if.source  result
);

  localparam int KW = wsd_pkg::KEPT_W;

  logic               push;
  logic               pop;
  wsd_pkg::item_t     push_item;
  wsd_pkg::item_t     head_item;
  wsd_pkg::q_status_t qstat;

  // Parse bytes into items
  wsd_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .frame (frame),
    .space (qstat.has_space),
    .push  (push),
    .item  (push_item)
  );

  // Decouple parser from result stage
  wsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (qstat)
  );

  // Decide replies and present results
  wsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .status    (qstat),
    .head_item (head_item),
    .pop       (pop),
    .result    (result)
  );

  `WSD_ASSERT_SAME(a_reply_only_last, result.valid && !result.last_of_frame, result.reply_action == wsd_pkg::REPLY_NONE, "reply action on an item that is not last")
  `WSD_ASSERT_SAME(a_marker_shape, result.valid && !result.has_data, result.data_byte == 8'd0 && result.kept_length == '0 && result.last_of_frame, "malformed empty-frame marker")
  `WSD_ASSERT_SAME(a_trunc_length, result.valid && result.last_of_frame && result.was_truncated, result.kept_length == KW'(BUFFER_BYTES - 1), "truncated frame not clipped to buffer")
  `WSD_ASSERT_NEXT(a_queue_no_invent, !qstat.has_item && !push, !qstat.has_item, "queue shows an item never pushed")

endmodule
